/* sv/timed_event_queue_macros.svh */
// Assertion macros for the timed event queue.
// The plain form is disabled while reset is asserted; the _NR form is checked
// at every clock edge, including those inside reset.
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

`define TEQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("timed event queue assertion failed");

`define TEQ_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("timed event queue assertion failed");

`else

`define TEQ_ASSERT(label, clk, rst_n, prop)

`define TEQ_ASSERT_NR(label, clk, prop)

`endif

`endif

/* sv/teq_pkg.sv */
`timescale 1ns / 1ps

package teq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    // APB address: byte address 4*i, register index in the upper bits.
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_MAX_COMMAND = '0;
    localparam logic [7:0] MAX_COMMAND_RST = 8'd8;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POLL   = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUE      = 3'd2;
    localparam logic [2:0] ST_BAD      = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    typedef struct packed {
        logic               req_type;
        logic [31:0]        event_time;
        logic [31:0]        now_time;
        logic [15:0]        owner_id;
        logic [7:0]         command;
        logic signed [15:0] arg_a;
        logic signed [15:0] arg_b;
        logic signed [15:0] arg_c;
        logic signed [15:0] arg_d;
        logic signed [15:0] arg_e;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        out_time;
        logic [15:0]        out_owner;
        logic [7:0]         out_command;
        logic signed [15:0] out_arg_a;
        logic signed [15:0] out_arg_b;
        logic signed [15:0] out_arg_c;
        logic signed [15:0] out_arg_d;
        logic signed [15:0] out_arg_e;
        logic               last_result;
    } t_out_word;

    // One stored event; arg_a sits in bits 15:0 of ent_args, arg_d in 63:48.
    typedef struct packed {
        logic [31:0] ent_time;
        logic [15:0] ent_owner;
        logic [7:0]  ent_command;
        logic [63:0] ent_args;
        logic [15:0] ent_arg_last;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_WR,
        S_POP,
        S_LAST
    } t_state;

endpackage

/* sv/timed_event_queue.sv */
`timescale 1ns / 1ps

// Channel  Signals                              Direction  Word
// input    i_in_valid, o_in_stall, i_in_word   in         insert or poll request
// output   o_out_valid, i_out_stall, o_out_word out       status / emitted event
// config   psel, penable, pwrite, paddr, ...    in         max_command at address 0
//
// An insert scans from the back and moves each stored event with a later time
// back one slot, one per cycle; a full queue is only reported. A poll emits due
// events from the front; with nothing due or an empty queue it reports none.
// One request is worked on at a time; o_in_stall is low only when idle.
// Reset clears the count, the head pointer and the control state; the event
// memory itself is not cleared. Output stalls hold the machine in place.

`include "timed_event_queue_macros.svh"

module timed_event_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  teq_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output teq_pkg::t_out_word                o_out_word,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [teq_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int IDX_W = teq_pkg::IDX_W;
    localparam int CNT_W = teq_pkg::CNT_W;
    localparam int RES_W = teq_pkg::RES_W;
    localparam int SUM_W = CNT_W + 1;

    // Event memory, a circular buffer whose front sits at r_head.
    teq_pkg::t_entry    mem [teq_pkg::QUEUE_DEPTH];
    teq_pkg::t_entry    r_rd;

    teq_pkg::t_state    r_state;
    teq_pkg::t_state    n_state;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_pos;
    logic [RES_W-1:0]   r_n;
    logic               r_have_pend;
    teq_pkg::t_in_word  r_req;
    teq_pkg::t_out_word r_pend;
    logic [7:0]         r_max_command;
    logic               r_out_valid;
    teq_pkg::t_out_word r_out_word;

    logic               acc;
    logic               out_free;
    logic               rd_later;
    logic               rd_due;
    logic               rd_bad;
    logic               step_ok;
    logic               run_end;
    logic               mem_re;
    logic [CNT_W-1:0]   rd_log;
    logic               mem_we;
    logic [CNT_W-1:0]   wr_log;
    teq_pkg::t_entry    mem_wdata;
    logic               emit;
    teq_pkg::t_out_word emit_word;
    logic               cfg_wr;

    function automatic logic [IDX_W-1:0] f_phys(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] offs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(offs);
        if (sum >= SUM_W'(teq_pkg::QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(teq_pkg::QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic teq_pkg::t_entry f_entry(input teq_pkg::t_in_word req);
        teq_pkg::t_entry e;
        e.ent_time     = req.event_time;
        e.ent_owner    = req.owner_id;
        e.ent_command  = req.command;
        e.ent_args     = {req.arg_d, req.arg_c, req.arg_b, req.arg_a};
        e.ent_arg_last = req.arg_e;
        return e;
    endfunction

    function automatic teq_pkg::t_out_word f_event(input teq_pkg::t_entry e,
                                                   input logic [2:0] status);
        teq_pkg::t_out_word w;
        w.status      = status;
        w.out_time    = e.ent_time;
        w.out_owner   = e.ent_owner;
        w.out_command = e.ent_command;
        w.out_arg_a   = e.ent_args[15:0];
        w.out_arg_b   = e.ent_args[31:16];
        w.out_arg_c   = e.ent_args[47:32];
        w.out_arg_d   = e.ent_args[63:48];
        w.out_arg_e   = e.ent_arg_last;
        w.last_result = 1'b0;
        return w;
    endfunction

    function automatic teq_pkg::t_out_word f_status(input logic [2:0] status);
        teq_pkg::t_out_word w;
        w        = '0;
        w.status = status;
        return w;
    endfunction

    assign acc      = i_in_valid && (r_state == teq_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_later = r_rd.ent_time > r_req.event_time;
    assign rd_due   = r_rd.ent_time <= r_req.now_time;
    assign rd_bad   = r_rd.ent_command > r_max_command;
    assign step_ok  = !r_have_pend || out_free;
    // The event being popped closes the run.
    assign run_end  = rd_bad || (r_n + RES_W'(1) == RES_W'(teq_pkg::MAX_RESULTS))
                      || (r_count == CNT_W'(1));

    assign o_in_stall  = (r_state != teq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            teq_pkg::S_IDLE: begin
                if (acc) begin
                    if (i_in_word.req_type == teq_pkg::REQ_INSERT) begin
                        if (r_count == CNT_W'(teq_pkg::QUEUE_DEPTH)) begin
                            n_state = teq_pkg::S_LAST;
                        end else if (r_count == '0) begin
                            n_state = teq_pkg::S_INS_WR;
                        end else begin
                            n_state = teq_pkg::S_INS_CMP;
                        end
                    end else if (r_count == '0) begin
                        n_state = teq_pkg::S_LAST;
                    end else begin
                        n_state = teq_pkg::S_POP;
                    end
                end
            end
            teq_pkg::S_INS_CMP: begin
                if (!rd_later) begin
                    n_state = teq_pkg::S_LAST;
                end else if (r_pos > CNT_W'(1)) begin
                    n_state = teq_pkg::S_INS_CMP;
                end else begin
                    n_state = teq_pkg::S_INS_WR;
                end
            end
            teq_pkg::S_INS_WR: begin
                n_state = teq_pkg::S_LAST;
            end
            teq_pkg::S_POP: begin
                if (rd_due) begin
                    if (step_ok && run_end) begin
                        n_state = teq_pkg::S_LAST;
                    end
                end else if (!r_have_pend) begin
                    n_state = teq_pkg::S_LAST;
                end else if (out_free) begin
                    n_state = teq_pkg::S_IDLE;
                end
            end
            teq_pkg::S_LAST: begin
                if (out_free) begin
                    n_state = teq_pkg::S_IDLE;
                end
            end
            default: n_state = teq_pkg::S_IDLE;
        endcase
    end

    // Memory access and emission.
    always_comb begin
        mem_re    = 1'b0;
        rd_log    = '0;
        mem_we    = 1'b0;
        wr_log    = r_pos;
        mem_wdata = f_entry(r_req);
        emit      = 1'b0;
        emit_word = r_pend;
        unique case (r_state)
            teq_pkg::S_IDLE: begin
                if (acc && r_count != '0) begin
                    if (i_in_word.req_type == teq_pkg::REQ_POLL) begin
                        mem_re = 1'b1;
                    end else if (r_count != CNT_W'(teq_pkg::QUEUE_DEPTH)) begin
                        // Scan from the back: start with the last stored event.
                        mem_re = 1'b1;
                        rd_log = r_count - CNT_W'(1);
                    end
                end
            end
            teq_pkg::S_INS_CMP: begin
                mem_we = 1'b1;
                if (rd_later) begin
                    mem_wdata = r_rd;
                    if (r_pos > CNT_W'(1)) begin
                        mem_re = 1'b1;
                        rd_log = r_pos - CNT_W'(2);
                    end
                end
            end
            teq_pkg::S_INS_WR: begin
                mem_we = 1'b1;
            end
            teq_pkg::S_POP: begin
                if (rd_due) begin
                    emit = r_have_pend && out_free;
                    if (step_ok && !run_end) begin
                        mem_re = 1'b1;
                        rd_log = CNT_W'(1);
                    end
                end else begin
                    emit                  = r_have_pend && out_free;
                    emit_word.last_result = 1'b1;
                end
            end
            teq_pkg::S_LAST: begin
                emit                  = out_free;
                emit_word.last_result = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[f_phys(r_head, wr_log)] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= mem[f_phys(r_head, rd_log)];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= teq_pkg::S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                teq_pkg::S_IDLE: begin
                    r_have_pend <= 1'b0;
                end
                teq_pkg::S_INS_CMP: begin
                    if (!rd_later) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                teq_pkg::S_INS_WR: begin
                    r_count <= r_count + CNT_W'(1);
                end
                teq_pkg::S_POP: begin
                    if (rd_due && step_ok) begin
                        r_have_pend <= 1'b1;
                        r_head      <= f_phys(r_head, CNT_W'(1));
                        r_count     <= r_count - CNT_W'(1);
                    end
                end
                teq_pkg::S_LAST: begin
                    r_have_pend <= 1'b0;
                end
                default: begin
                    r_have_pend <= 1'b0;
                end
            endcase
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= emit_word;
        end
        unique case (r_state)
            teq_pkg::S_IDLE: begin
                if (acc) begin
                    r_req <= i_in_word;
                    r_n   <= '0;
                    r_pos <= r_count;
                    if (i_in_word.req_type == teq_pkg::REQ_INSERT) begin
                        r_pend <= f_status(teq_pkg::ST_FULL);
                    end else begin
                        r_pend <= f_status(teq_pkg::ST_NONE);
                    end
                end
            end
            teq_pkg::S_INS_CMP: begin
                if (rd_later) begin
                    r_pos <= r_pos - CNT_W'(1);
                end else begin
                    r_pend <= f_status(teq_pkg::ST_INSERTED);
                end
            end
            teq_pkg::S_INS_WR: begin
                r_pend <= f_status(teq_pkg::ST_INSERTED);
            end
            teq_pkg::S_POP: begin
                if (rd_due) begin
                    if (step_ok) begin
                        r_pend <= f_event(r_rd, rd_bad ? teq_pkg::ST_BAD : teq_pkg::ST_DUE);
                        r_n    <= r_n + RES_W'(1);
                    end
                end else if (!r_have_pend) begin
                    r_pend <= f_status(teq_pkg::ST_NONE);
                end
            end
            teq_pkg::S_LAST: begin
                r_n <= r_n;
            end
            default: begin
                r_n <= r_n;
            end
        endcase
    end

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_command <= teq_pkg::MAX_COMMAND_RST;
        end else if (cfg_wr && paddr[teq_pkg::PADDR_W-1:2] == teq_pkg::REG_MAX_COMMAND) begin
            r_max_command <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[teq_pkg::PADDR_W-1:2] == teq_pkg::REG_MAX_COMMAND) begin
            prdata = {24'd0, r_max_command};
        end
    end

    `TEQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(teq_pkg::QUEUE_DEPTH))
    `TEQ_ASSERT(a_pop_nonempty, i_clk, i_rst_n, (r_state == teq_pkg::S_POP) |-> (r_count != '0))
    `TEQ_ASSERT(a_idle_no_write, i_clk, i_rst_n, (r_state == teq_pkg::S_IDLE) |-> !mem_we)
    `TEQ_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> (r_state == teq_pkg::S_IDLE && !r_out_valid))

endmodule
